// ===== hw/rtl/glf_pkg.sv =====
// Package with the shared types, character codes and helpers of the G-code line filter.
`default_nettype none

package glf_pkg;

  localparam int unsigned LineMax  = 256;
  localparam int unsigned LenWidth = 9;

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChPct    = 8'h25;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowZ   = 8'h7A;
  localparam logic [7:0] CaseBit  = 8'h20;

  localparam logic [LenWidth-1:0] LineMaxVal = LenWidth'(LineMax);

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_valid;
    logic [7:0] out_position;
    logic       line_end;
    logic       overflow;
    logic [7:0] comment_char;
    logic       comment_valid;
    logic       comment_restart;
    logic       comment_end;
  } result_t;

  // ASCII upper-case for a..z only.
  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] u;
    u = c;
    if (c >= ChLowA && c <= ChLowZ) begin
      u = c & ~CaseBit;
    end
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gcode_line_filter_core.sv =====
// Top level of the G-code line filter: input register, line parser, result register.
//
// Usage:
//   Input channel: one text character per transfer on byte_in_i, taken at a rising
//   edge with in_valid_i high and in_stall_o low. A zero byte ends the line.
//   Result channel: exactly one result per character, offered on res_valid_o and
//   taken at an edge with res_stall_i low. It carries the upper-cased line
//   character and its position, the comment text character, and the line end,
//   overflow, comment restart and comment end flags.
//   Configuration: cfg_we_i writes cfg_wdata_i into the line length limit (values
//   above 256 act as 256). Write it only while no character is in flight.
// Pipeline: a character passes two register stages, the input register and then
//   the result register.
// Throughput: one character per cycle while res_stall_i is low; the parser updates
//   its flags and fill count in the same cycle the character moves into the result register.
// Reset: clears both comment flags, the fill count and the stage valid bits, and
//   sets the length limit to 256.
// Receiver stall: the result register holds; the input register holds its
//   character and raises in_stall_o, so at most two characters wait inside.
`default_nettype none

module gcode_line_filter_core
  import glf_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [LenWidth-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [7:0]          byte_in_i,
  output logic                     res_valid_o,
  input  wire logic                res_stall_i,
  output logic [7:0]               out_char_o,
  output logic                     out_valid_o,
  output logic [7:0]               out_position_o,
  output logic                     line_end_o,
  output logic                     overflow_o,
  output logic [7:0]               comment_char_o,
  output logic                     comment_valid_o,
  output logic                     comment_restart_o,
  output logic                     comment_end_o
);

  logic       advance;
  logic       item_valid;
  logic [7:0] item_byte;
  logic       step;
  result_t    step_res;
  result_t    res_q;

  // Hold the character until the result register can take its result.
  glf_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .byte_in_i   (byte_in_i),
    .advance_i   (advance),
    .item_valid_o(item_valid),
    .item_byte_o (item_byte)
  );

  // Parser state moves only when a character transfers into the result register.
  assign step = item_valid && advance;

  glf_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .step_i     (step),
    .byte_i     (item_byte),
    .result_o   (step_res)
  );

  glf_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_valid_i(item_valid),
    .load_data_i (step_res),
    .advance_o   (advance),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .res_data_o  (res_q)
  );

  assign out_char_o        = res_q.out_char;
  assign out_valid_o       = res_q.out_valid;
  assign out_position_o    = res_q.out_position;
  assign line_end_o        = res_q.line_end;
  assign overflow_o        = res_q.overflow;
  assign comment_char_o    = res_q.comment_char;
  assign comment_valid_o   = res_q.comment_valid;
  assign comment_restart_o = res_q.comment_restart;
  assign comment_end_o     = res_q.comment_end;

endmodule

`default_nettype wire

// ===== hw/rtl/glf_in_stage.sv =====
// Input register of the G-code line filter: holds one character until the parser takes it.
`default_nettype none

module glf_in_stage
  import glf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] byte_in_i,
  input  wire logic       advance_i,
  output logic            item_valid_o,
  output logic [7:0]      item_byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       take;

  // Refill whenever the held character moves on or the register is empty.
  assign in_stall_o = valid_q && !advance_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (take) begin
      valid_d = 1'b1;
      byte_d  = byte_in_i;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign item_valid_o = valid_q;
  assign item_byte_o  = byte_q;

endmodule

`default_nettype wire

// ===== hw/rtl/glf_parser.sv =====
// Line parser of the G-code line filter: comment flags, fill count, length limit, result.
`default_nettype none

module glf_parser
  import glf_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [LenWidth-1:0] cfg_wdata_i,
  input  wire logic                step_i,
  input  wire logic [7:0]          byte_i,
  output result_t                  result_o
);

  logic                paren_q, paren_d;
  logic                semi_q, semi_d;
  logic [LenWidth-1:0] fill_q, fill_d;
  logic                wrap_q, wrap_d;
  logic [LenWidth-1:0] max_len_q;
  logic [LenWidth-1:0] limit;
  result_t             res;

  assign limit = (max_len_q > LineMaxVal) ? LineMaxVal : max_len_q;

  always_comb begin
    paren_d = paren_q;
    semi_d  = semi_q;
    fill_d  = fill_q;
    wrap_d  = wrap_q;
    res     = '0;
    if (byte_i == ChNul) begin
      res.line_end = 1'b1;
      paren_d      = 1'b0;
      semi_d       = 1'b0;
      fill_d       = '0;
      wrap_d       = 1'b0;
    end else begin
      // Capture everything while a parenthesis comment is open.
      if (paren_q) begin
        res.comment_char  = byte_i;
        res.comment_valid = 1'b1;
      end
      if (byte_i == ChNl) begin
        res.line_end = 1'b1;
        paren_d      = 1'b0;
        semi_d       = 1'b0;
        fill_d       = '0;
        wrap_d       = 1'b0;
      end else begin
        case (byte_i)
          ChCr, ChSpace, ChPct: begin
          end
          ChLParen: begin
            res.comment_restart = paren_q;
            paren_d             = 1'b1;
          end
          ChRParen: begin
            if (paren_q) begin
              paren_d         = 1'b0;
              res.comment_end = 1'b1;
            end
          end
          ChSemi: begin
            if (!paren_q) begin
              semi_d = 1'b1;
            end
          end
          default: begin
            if (!paren_q && !semi_q) begin
              res.out_char     = to_upper(byte_i);
              res.out_valid    = 1'b1;
              res.out_position = fill_q[7:0];
              fill_d           = fill_q + LenWidth'(1);
              // A wrapped count has already passed every limit; hold off the check.
              if (fill_q == '1) begin
                wrap_d = 1'b1;
              end
            end
          end
        endcase
        if (!wrap_d && fill_d == limit) begin
          res.line_end = 1'b1;
          res.overflow = 1'b1;
          paren_d      = 1'b0;
          semi_d       = 1'b0;
          fill_d       = '0;
          wrap_d       = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paren_q   <= 1'b0;
      semi_q    <= 1'b0;
      fill_q    <= '0;
      wrap_q    <= 1'b0;
      max_len_q <= LineMaxVal;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      if (step_i) begin
        paren_q <= paren_d;
        semi_q  <= semi_d;
        fill_q  <= fill_d;
        wrap_q  <= wrap_d;
      end
    end
  end

  assign result_o = res;

endmodule

`default_nettype wire

// ===== hw/rtl/glf_out_stage.sv =====
// Result register of the G-code line filter: holds one result until the receiver takes it.
`default_nettype none

module glf_out_stage
  import glf_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic load_valid_i,
  input  result_t   load_data_i,
  output logic      advance_o,
  output logic      res_valid_o,
  input  wire logic res_stall_i,
  output result_t   res_data_o
);

  logic    valid_q, valid_d;
  result_t data_q, data_d;

  // Advance when the register is empty or its result leaves this cycle.
  assign advance_o = !valid_q || !res_stall_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (advance_o) begin
      valid_d = load_valid_i;
      data_d  = load_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign res_valid_o = valid_q;
  assign res_data_o  = data_q;

endmodule

`default_nettype wire
